// ----- hw/rtl/histogram_median_filter_core_assert.svh -----
// Assertion macros for the median filter core.
`ifndef HISTOGRAM_MEDIAN_FILTER_CORE_ASSERT_SVH
`define HISTOGRAM_MEDIAN_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define HMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/hmf_pkg.sv -----
`default_nettype none
package hmf_pkg;

  localparam int BIN_W     = 12;
  localparam int HIST_BINS = 256;
  localparam int BIN_AW    = 8;
  localparam int PIX_W     = 8;

  localparam int SIZE_REG_W = 8;
  localparam int WIN_REG_W  = 6;

  localparam logic [SIZE_REG_W-1:0] IMAGE_WIDTH_RST  = 8'd128;
  localparam logic [SIZE_REG_W-1:0] IMAGE_HEIGHT_RST = 8'd128;
  localparam logic [WIN_REG_W-1:0]  WINDOW_WIDTH_RST  = 6'd3;
  localparam logic [WIN_REG_W-1:0]  WINDOW_HEIGHT_RST = 6'd3;

  // register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd2;
  localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd3;

  // run phases
  localparam logic [1:0] PH_LOADING = 2'd0;
  localparam logic [1:0] PH_RUNNING = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

endpackage
`default_nettype wire

// ----- hw/rtl/histogram_median_filter_core.sv -----
`default_nettype none
// Sliding-window median filter over a stored gray image (256-bin histogram).
// Command channel: a word (mode, pixel_value) is taken when start is high and
// busy is low. mode 0 loads the next pixel in raster order; mode 1 requests
// the next filtered pixel. Results appear for one cycle with out_valid; the
// receiver cannot stall, so there is no back-pressure on the result side.
// Each load stores one pixel. The load that completes the image starts a run:
// a clear of all 256 histogram bins, then each pixel of the first window is added.
// A request scans the histogram memory from bin 0 up to the median bin, the
// result shows, then the window step pops and pushes one window side, each
// pixel by reading the image, reading its bin and writing the bin back.
// Requests while loading or after the last pixel give no result; loads while
// running are ignored; a load after the last pixel starts a new image.
// Registers are sampled at the first pixel of an image.
// Reset: synchronous; phase goes to loading, registers to their defaults.
// Image memory content is undefined until loaded.
module histogram_median_filter_core #(
  parameter int MAX_IMAGE_WIDTH  = 128,
  parameter int MAX_IMAGE_HEIGHT = 128,
  parameter int MAX_WINDOW       = 63
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [7:0]  pixel_value,
  output logic             out_valid,
  output logic [6:0]       out_x,
  output logic [6:0]       out_y,
  output logic [7:0]       median_value,
  output logic             last_pixel,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int XW    = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int YW    = $clog2(MAX_IMAGE_HEIGHT + 1);
  localparam int WW    = $clog2(MAX_WINDOW + 1);
  localparam int MW    = (XW > YW) ? XW : YW;
  localparam int SW    = ((MW > WW) ? MW : WW) + 2;
  localparam int AW    = 2 * WW + 1;
  localparam int DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int SAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_LADDR = 3'd2;
  localparam logic [2:0] ST_LBIN  = 3'd3;
  localparam logic [2:0] ST_LWR   = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;

  localparam logic [1:0] SEG_FILL = 2'd0;
  localparam logic [1:0] SEG_POP  = 2'd1;
  localparam logic [1:0] SEG_PUSH = 2'd2;

  localparam logic [1:0] MV_RIGHT = 2'd0;
  localparam logic [1:0] MV_LEFT  = 2'd1;
  localparam logic [1:0] MV_DOWN  = 2'd2;

  // configuration registers
  logic [hmf_pkg::SIZE_REG_W-1:0] image_width, image_height;
  logic [hmf_pkg::WIN_REG_W-1:0]  window_width, window_height;

  // working copies
  logic [XW-1:0]  cur_iw;
  logic [YW-1:0]  cur_ih;
  logic [WW-1:0]  cur_ww, cur_wh;
  logic [AW-1:0]  need;
  logic [SAW:0]   total;
  logic [SAW:0]   load_cnt;
  logic [1:0]     phase;
  logic [XW-1:0]  col;
  logic [YW-1:0]  row;

  logic [2:0]     state;
  logic [1:0]     seg, mv;
  logic [hmf_pkg::BIN_AW-1:0] clr_i;
  logic [WW-1:0]  fill_r;
  logic signed [SW-1:0] lx, ly;
  logic [WW-1:0]  lcnt;
  logic           ldir_y, ladd;
  logic [hmf_pkg::BIN_AW-1:0] bin_reg;

  logic [hmf_pkg::BIN_AW:0]   scan_i;
  logic                       rd_vld;
  logic [hmf_pkg::BIN_AW-1:0] rd_idx;
  logic [AW-1:0]              acc;

  // memories
  logic [hmf_pkg::PIX_W-1:0] store [DEPTH];
  logic [hmf_pkg::PIX_W-1:0] store_q;
  logic                      store_we;
  logic [SAW-1:0]            store_waddr, store_raddr;
  logic [hmf_pkg::BIN_W-1:0] hist [hmf_pkg::HIST_BINS];
  logic [hmf_pkg::BIN_W-1:0] hist_q, hist_wdata;
  logic                      hist_we;
  logic [hmf_pkg::BIN_AW-1:0] hist_waddr, hist_raddr;

  // ---------------- configuration port ----------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= hmf_pkg::IMAGE_WIDTH_RST;
      image_height  <= hmf_pkg::IMAGE_HEIGHT_RST;
      window_width  <= hmf_pkg::WINDOW_WIDTH_RST;
      window_height <= hmf_pkg::WINDOW_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        hmf_pkg::REG_IMAGE_WIDTH:   image_width   <= pwdata[hmf_pkg::SIZE_REG_W-1:0];
        hmf_pkg::REG_IMAGE_HEIGHT:  image_height  <= pwdata[hmf_pkg::SIZE_REG_W-1:0];
        hmf_pkg::REG_WINDOW_WIDTH:  window_width  <= pwdata[hmf_pkg::WIN_REG_W-1:0];
        hmf_pkg::REG_WINDOW_HEIGHT: window_height <= pwdata[hmf_pkg::WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hmf_pkg::REG_IMAGE_WIDTH:   prdata = 32'(image_width);
      hmf_pkg::REG_IMAGE_HEIGHT:  prdata = 32'(image_height);
      hmf_pkg::REG_WINDOW_WIDTH:  prdata = 32'(window_width);
      hmf_pkg::REG_WINDOW_HEIGHT: prdata = 32'(window_height);
      default:                    prdata = '0;
    endcase
  end

  // ---------------- saturated sizes ----------------
  logic [XW-1:0] sat_iw;
  logic [YW-1:0] sat_ih;
  logic [WW-1:0] sat_ww, sat_wh;
  logic [SAW:0]  sat_total;
  logic [AW-1:0] sat_cnt;

  always_comb begin
    if (image_width == '0) sat_iw = XW'(1);
    else if (32'(image_width) > MAX_IMAGE_WIDTH) sat_iw = XW'(MAX_IMAGE_WIDTH);
    else sat_iw = XW'(image_width);
    if (image_height == '0) sat_ih = YW'(1);
    else if (32'(image_height) > MAX_IMAGE_HEIGHT) sat_ih = YW'(MAX_IMAGE_HEIGHT);
    else sat_ih = YW'(image_height);
    if (window_width == '0) sat_ww = WW'(1);
    else if (32'(window_width) > MAX_WINDOW) sat_ww = WW'(MAX_WINDOW);
    else sat_ww = WW'(window_width);
    if (window_height == '0) sat_wh = WW'(1);
    else if (32'(window_height) > MAX_WINDOW) sat_wh = WW'(MAX_WINDOW);
    else sat_wh = WW'(window_height);
  end

  assign sat_total = (SAW+1)'(sat_iw) * (SAW+1)'(sat_ih);
  assign sat_cnt   = AW'(sat_ww) * AW'(sat_wh);

  // ---------------- window offsets ----------------
  logic signed [SW-1:0] ww_half, wh_half, lo_w, hi_w, lo_h, hi_h, col_s, row_s;
  logic signed [SW-1:0] iw_m1, ih_m1;

  assign ww_half = SW'(cur_ww >> 1);
  assign wh_half = SW'(cur_wh >> 1);
  assign lo_w    = -ww_half;
  assign lo_h    = -wh_half;
  assign hi_w    = ww_half - SW'(!cur_ww[0]);
  assign hi_h    = wh_half - SW'(!cur_wh[0]);
  assign col_s   = SW'(col);
  assign row_s   = SW'(row);
  assign iw_m1   = SW'(cur_iw) - SW'(1);
  assign ih_m1   = SW'(cur_ih) - SW'(1);

  // clamp to the image and form the store address
  logic [XW-1:0]    xc;
  logic [YW-1:0]    yc;
  logic [XW+YW-1:0] lin_addr;

  always_comb begin
    if (lx < 0) xc = '0;
    else if (lx > iw_m1) xc = XW'(iw_m1);
    else xc = XW'(lx);
    if (ly < 0) yc = '0;
    else if (ly > ih_m1) yc = YW'(ih_m1);
    else yc = YW'(ly);
  end

  assign lin_addr    = (XW+YW)'(yc) * (XW+YW)'(cur_iw) + (XW+YW)'(xc);
  assign store_raddr = SAW'(lin_addr);

  // ---------------- accept / scan helpers ----------------
  logic          accept, is_load, is_req;
  logic [SAW:0]  eff_cnt, cnt_next, tot_now;
  logic [AW-1:0] acc_new;
  logic          scan_hit;
  logic [hmf_pkg::BIN_AW-1:0] scan_med;
  logic          fw_ok, bw_ok, dn_ok;

  assign busy     = (state != ST_IDLE);
  assign accept   = start & ~busy;
  assign is_load  = accept & ~mode;
  assign is_req   = accept & mode;
  assign eff_cnt  = (phase == hmf_pkg::PH_DONE) ? '0 : load_cnt;
  assign cnt_next = eff_cnt + (SAW+1)'(1);
  assign tot_now  = (eff_cnt == '0) ? sat_total : total;

  assign acc_new = acc + AW'(hist_q);

  always_comb begin
    scan_hit = 1'b0;
    scan_med = rd_idx;
    if (rd_vld) begin
      if (acc_new >= need) begin
        scan_hit = 1'b1;
      end else if (rd_idx == hmf_pkg::BIN_AW'(hmf_pkg::HIST_BINS - 1)) begin
        scan_hit = 1'b1;
        scan_med = '0;
      end
    end
  end

  assign fw_ok = ~row[0] & (SW'(col) < iw_m1);
  assign bw_ok = row[0] & (col != '0);
  assign dn_ok = (SW'(row) < ih_m1);

  // ---------------- memory ports ----------------
  assign store_we    = is_load & (phase != hmf_pkg::PH_RUNNING);
  assign store_waddr = eff_cnt[SAW-1:0];

  always_ff @(posedge clk) begin
    if (store_we) store[store_waddr] <= pixel_value;
    store_q <= store[store_raddr];
  end

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = bin_reg;
    hist_wdata = ladd ? hist_q + hmf_pkg::BIN_W'(1) : hist_q - hmf_pkg::BIN_W'(1);
    hist_raddr = (state == ST_SCAN) ? scan_i[hmf_pkg::BIN_AW-1:0] : store_q;
    if (state == ST_CLEAR) begin
      hist_we    = 1'b1;
      hist_waddr = clr_i;
      hist_wdata = '0;
    end else if (state == ST_LWR) begin
      hist_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist[hist_waddr] <= hist_wdata;
    hist_q <= hist[hist_raddr];
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= hmf_pkg::PH_LOADING;
      load_cnt  <= '0;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
      cur_iw    <= XW'(hmf_pkg::IMAGE_WIDTH_RST);
      cur_ih    <= YW'(hmf_pkg::IMAGE_HEIGHT_RST);
      cur_ww    <= WW'(hmf_pkg::WINDOW_WIDTH_RST);
      cur_wh    <= WW'(hmf_pkg::WINDOW_HEIGHT_RST);
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (is_load && phase != hmf_pkg::PH_RUNNING) begin
            phase    <= hmf_pkg::PH_LOADING;
            load_cnt <= cnt_next;
            if (eff_cnt == '0) begin
              cur_iw <= sat_iw;
              cur_ih <= sat_ih;
              cur_ww <= sat_ww;
              cur_wh <= sat_wh;
              total  <= sat_total;
              need   <= AW'((sat_cnt + AW'(1)) >> 1);
            end
            if (cnt_next >= tot_now) begin
              col    <= '0;
              row    <= '0;
              clr_i  <= '0;
              fill_r <= '0;
              seg    <= SEG_FILL;
              state  <= ST_CLEAR;
            end
          end else if (is_req && phase == hmf_pkg::PH_RUNNING) begin
            scan_i <= '0;
            rd_vld <= 1'b0;
            acc    <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_CLEAR: begin
          clr_i <= clr_i + hmf_pkg::BIN_AW'(1);
          if (clr_i == hmf_pkg::BIN_AW'(hmf_pkg::HIST_BINS - 1)) begin
            lx     <= lo_w;
            ly     <= lo_h;
            lcnt   <= cur_ww;
            ldir_y <= 1'b0;
            ladd   <= 1'b1;
            state  <= ST_LADDR;
          end
        end
        ST_LADDR: state <= ST_LBIN;
        ST_LBIN: begin
          bin_reg <= store_q;
          state   <= ST_LWR;
        end
        ST_LWR: begin
          if (lcnt != WW'(1)) begin
            lcnt  <= lcnt - WW'(1);
            if (ldir_y) ly <= ly + SW'(1);
            else lx <= lx + SW'(1);
            state <= ST_LADDR;
          end else begin
            unique case (seg)
              SEG_FILL: begin
                if (fill_r == cur_wh - WW'(1)) begin
                  phase <= hmf_pkg::PH_RUNNING;
                  state <= ST_IDLE;
                end else begin
                  fill_r <= fill_r + WW'(1);
                  lx     <= lo_w;
                  ly     <= lo_h + SW'(fill_r) + SW'(1);
                  lcnt   <= cur_ww;
                  state  <= ST_LADDR;
                end
              end
              SEG_POP: begin
                seg   <= SEG_PUSH;
                ladd  <= 1'b1;
                state <= ST_LADDR;
                unique case (mv)
                  MV_RIGHT: begin
                    col  <= col + XW'(1);
                    lx   <= col_s + SW'(1) + hi_w;
                    ly   <= row_s + lo_h;
                    lcnt <= cur_wh;
                  end
                  MV_LEFT: begin
                    col  <= col - XW'(1);
                    lx   <= col_s - SW'(1) + lo_w;
                    ly   <= row_s + lo_h;
                    lcnt <= cur_wh;
                  end
                  default: begin
                    row  <= row + YW'(1);
                    lx   <= col_s + lo_w;
                    ly   <= row_s + SW'(1) + hi_h;
                    lcnt <= cur_ww;
                  end
                endcase
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_i[hmf_pkg::BIN_AW] == 1'b0) begin
            rd_vld <= 1'b1;
            rd_idx <= scan_i[hmf_pkg::BIN_AW-1:0];
            scan_i <= scan_i + (hmf_pkg::BIN_AW+1)'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) acc <= acc_new;
          if (scan_hit) begin
            out_valid    <= 1'b1;
            out_x        <= 7'(col);
            out_y        <= 7'(row);
            median_value <= 8'(scan_med);
            last_pixel   <= ~(fw_ok | bw_ok | dn_ok);
            seg          <= SEG_POP;
            ladd         <= 1'b0;
            state        <= ST_LADDR;
            if (fw_ok || bw_ok) begin
              mv     <= fw_ok ? MV_RIGHT : MV_LEFT;
              lx     <= fw_ok ? col_s + lo_w : col_s + hi_w;
              ly     <= row_s + lo_h;
              lcnt   <= cur_wh;
              ldir_y <= 1'b1;
            end else if (dn_ok) begin
              mv     <= MV_DOWN;
              lx     <= col_s + lo_w;
              ly     <= row_s + lo_h;
              lcnt   <= cur_ww;
              ldir_y <= 1'b0;
            end else begin
              phase <= hmf_pkg::PH_DONE;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/hmf_checker.sv -----
`default_nettype none
`include "histogram_median_filter_core_assert.svh"
module hmf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic mode,
  input wire logic out_valid,
  input wire logic last_pixel
);

  // a result word is a single-cycle strobe
  `HMF_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")

  // the bin scan never finishes in the cycle after a request
  `HMF_ASSERT_NEXT(a_no_instant_result, start && !busy && mode, !out_valid, "result too early")

  // a result that is not the last one is followed by the window step
  `HMF_ASSERT_NOW(a_step_after_result, out_valid && !last_pixel, busy, "no window step")

  // the last result of an image leaves the block ready for commands
  `HMF_ASSERT_NOW(a_idle_after_last, out_valid && last_pixel, !busy, "busy after last")

endmodule

bind histogram_median_filter_core hmf_checker u_hmf_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .mode(mode),
  .out_valid(out_valid),
  .last_pixel(last_pixel)
);
`default_nettype wire
